// ===== rtl/gf2_equation_solver_defines.svh =====
// Assertion helpers for the solver top level.
`ifndef GF2_EQUATION_SOLVER_DEFINES_SVH
`define GF2_EQUATION_SOLVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GF2S_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GF2S_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gf2s_pkg.sv =====
package gf2s_pkg;

   localparam int COEFF_BITS  = 32;
   localparam int DATA_BITS   = 64;
   localparam int INDEX_BITS  = 5;
   localparam int CFG_BITS    = 6;

   localparam logic [CFG_BITS-1:0] SOURCE_BLOCKS_RESET = 6'd32;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_SOLVE = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_STORED  = 3'd0,
      ST_READY   = 3'd1,
      ST_SHORT   = 3'd2,
      ST_DROPPED = 3'd3,
      ST_SOLVED  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PIV,
      S_SRCH,
      S_SWAP,
      S_ELIM,
      S_BPIV,
      S_BSUB,
      S_EMIT
   } state_type;

   typedef struct packed {
      mode_type                mode;
      logic [COEFF_BITS-1:0]   coeff_mask;
      logic [DATA_BITS-1:0]    payload;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [INDEX_BITS-1:0]   row_index;
      logic [DATA_BITS-1:0]    block_value;
      logic                    pivot_missing;
      logic                    last;
   } rsp_type;

   // Row store write controls from the sequencer.
   typedef struct packed {
      logic coeff_we;
      logic pay_we;
      logic clear;
   } wr_ctl_type;

endpackage

// ===== rtl/gf2s_store.sv =====
module gf2s_store #(
   parameter int ROWS = 32,
   parameter int PB   = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gf2s_pkg::wr_ctl_type     wr_ctl,
   input  logic [$clog2(ROWS)-1:0]  wr_idx,
   input  logic [ROWS-1:0]          wr_coeff,
   input  logic [PB-1:0]            wr_pay,
   input  logic [$clog2(ROWS)-1:0]  rd_idx,
   output logic [ROWS-1:0]          rd_coeff,
   output logic [PB-1:0]            rd_pay
);
   import gf2s_pkg::*;

   logic [ROWS-1:0] coeff_ff [ROWS];
   logic [PB-1:0]   pay_ff   [ROWS];

   // Coefficient rows: cleared at reset and after each decode
   always_ff @(posedge clock) begin
      if (reset || wr_ctl.clear) begin
         for (int r = 0; r < ROWS; r++) begin
            coeff_ff[r] <= '0;
         end
      end else if (wr_ctl.coeff_we) begin
         coeff_ff[wr_idx] <= wr_coeff;
      end
   end

   // Payload rows: no reset, only written rows are read
   always_ff @(posedge clock) begin
      if (wr_ctl.pay_we) begin
         pay_ff[wr_idx] <= wr_pay;
      end
   end

   // Single read port
   assign rd_coeff = coeff_ff[rd_idx];
   assign rd_pay   = pay_ff[rd_idx];

endmodule

// ===== rtl/gf2s_seq.sv =====
module gf2s_seq #(
   parameter int ROWS = 32,
   parameter int PB   = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [$clog2(ROWS):0]    n,
   input  logic                     req_accept,
   input  gf2s_pkg::req_type        req_data,
   input  logic                     out_free,
   input  logic [ROWS-1:0]          rd_coeff,
   input  logic [PB-1:0]            rd_pay,
   output logic                     idle,
   output logic                     res_load,
   output gf2s_pkg::rsp_type        res,
   output gf2s_pkg::wr_ctl_type     wr_ctl,
   output logic [$clog2(ROWS)-1:0]  wr_idx,
   output logic [ROWS-1:0]          wr_coeff,
   output logic [PB-1:0]            wr_pay,
   output logic [$clog2(ROWS)-1:0]  rd_idx
);
   import gf2s_pkg::*;

   localparam int IW = $clog2(ROWS);
   localparam int CW = IW + 1;

   state_type       state_ff, state_in;
   logic [CW-1:0]   i_ff, i_in;
   logic [CW-1:0]   j_ff, j_in;
   logic [CW-1:0]   eq_ff, eq_in;
   logic [ROWS-1:0] miss_ff, miss_in;
   logic [ROWS-1:0] piv_c_ff, piv_c_in;
   logic [PB-1:0]   piv_p_ff, piv_p_in;

   logic [IW-1:0]   i_idx, j_idx, eq_idx;
   logic [ROWS-1:0] col_mask;
   logic [ROWS-1:0] xor_coeff;
   logic [PB-1:0]   xor_pay;
   logic            hit;
   logic            col_last;

   assign i_idx  = i_ff[IW-1:0];
   assign j_idx  = j_ff[IW-1:0];
   assign eq_idx = eq_ff[IW-1:0];

   // Columns in use
   always_comb begin
      for (int k = 0; k < ROWS; k++) begin
         col_mask[k] = (CW'(k) < n);
      end
   end

   // Shared row unit: pivot test and row XOR
   assign hit       = rd_coeff[i_idx];
   assign xor_coeff = rd_coeff ^ piv_c_ff;
   assign xor_pay   = rd_pay ^ piv_p_ff;
   assign col_last  = (CW'(i_ff + 1'b1) == n);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         eq_ff    <= '0;
         miss_ff  <= '0;
      end else begin
         state_ff <= state_in;
         eq_ff    <= eq_in;
         miss_ff  <= miss_in;
      end
   end

   // Counters and pivot row
   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      piv_c_ff <= piv_c_in;
      piv_p_ff <= piv_p_in;
   end

   // Next state and outputs
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      eq_in    = eq_ff;
      miss_in  = miss_ff;
      piv_c_in = piv_c_ff;
      piv_p_in = piv_p_ff;
      idle     = 1'b0;
      res_load = 1'b0;
      res      = '0;
      wr_ctl   = '0;
      wr_idx   = j_idx;
      wr_coeff = xor_coeff;
      wr_pay   = xor_pay;
      rd_idx   = i_idx;

      unique case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (req_accept) begin
               if (req_data.mode == MODE_LOAD) begin
                  res_load = 1'b1;
                  res.last = 1'b1;
                  if (eq_ff >= n) begin
                     res.status = ST_DROPPED;
                  end else begin
                     wr_ctl.coeff_we = 1'b1;
                     wr_ctl.pay_we   = 1'b1;
                     wr_idx   = eq_idx;
                     wr_coeff = req_data.coeff_mask[ROWS-1:0] & col_mask;
                     wr_pay   = req_data.payload[PB-1:0];
                     eq_in    = CW'(eq_ff + 1'b1);
                     res.status = (CW'(eq_ff + 1'b1) >= n) ? ST_READY : ST_STORED;
                  end
               end else if (eq_ff < n) begin
                  res_load   = 1'b1;
                  res.last   = 1'b1;
                  res.status = ST_SHORT;
               end else begin
                  miss_in  = '0;
                  i_in     = '0;
                  state_in = S_PIV;
               end
            end
         end

         // Latch row i as pivot candidate
         S_PIV: begin
            rd_idx   = i_idx;
            piv_c_in = rd_coeff;
            piv_p_in = rd_pay;
            j_in     = CW'(i_ff + 1'b1);
            state_in = hit ? S_ELIM : S_SRCH;
         end

         // Scan lower rows for a pivot
         S_SRCH: begin
            rd_idx = j_idx;
            if (j_ff >= n) begin
               miss_in[i_idx] = 1'b1;
               if (col_last) begin
                  state_in = S_BPIV;
               end else begin
                  i_in     = CW'(i_ff + 1'b1);
                  state_in = S_PIV;
               end
            end else begin
               j_in = CW'(j_ff + 1'b1);
               if (hit) begin
                  wr_ctl.coeff_we = 1'b1;
                  wr_ctl.pay_we   = 1'b1;
                  wr_coeff = piv_c_ff;
                  wr_pay   = piv_p_ff;
                  piv_c_in = rd_coeff;
                  piv_p_in = rd_pay;
                  state_in = S_SWAP;
               end
            end
         end

         // Put the found pivot row in place
         S_SWAP: begin
            wr_ctl.coeff_we = 1'b1;
            wr_ctl.pay_we   = 1'b1;
            wr_idx   = i_idx;
            wr_coeff = piv_c_ff;
            wr_pay   = piv_p_ff;
            state_in = S_ELIM;
         end

         // Clear column i below the pivot
         S_ELIM: begin
            rd_idx = j_idx;
            if (j_ff >= n) begin
               if (col_last) begin
                  state_in = S_BPIV;
               end else begin
                  i_in     = CW'(i_ff + 1'b1);
                  state_in = S_PIV;
               end
            end else begin
               j_in = CW'(j_ff + 1'b1);
               if (hit) begin
                  wr_ctl.coeff_we = 1'b1;
                  wr_ctl.pay_we   = 1'b1;
               end
            end
         end

         // Latch solved payload of row i
         S_BPIV: begin
            rd_idx   = i_idx;
            piv_p_in = rd_pay;
            j_in     = '0;
            state_in = S_BSUB;
         end

         // Fold row i into the rows above it
         S_BSUB: begin
            rd_idx = j_idx;
            if (j_ff >= i_ff) begin
               j_in = '0;
               if (i_ff == '0) begin
                  state_in = S_EMIT;
               end else begin
                  i_in     = CW'(i_ff - 1'b1);
                  state_in = S_BPIV;
               end
            end else begin
               j_in = CW'(j_ff + 1'b1);
               if (hit) begin
                  wr_ctl.pay_we = 1'b1;
               end
            end
         end

         // Emit one solved word per free output slot
         S_EMIT: begin
            rd_idx = j_idx;
            if (out_free) begin
               res_load          = 1'b1;
               res.status        = ST_SOLVED;
               res.row_index     = INDEX_BITS'(j_idx);
               res.block_value   = DATA_BITS'(rd_pay);
               res.pivot_missing = miss_ff[j_idx];
               res.last          = (CW'(j_ff + 1'b1) == n);
               if (res.last) begin
                  wr_ctl.clear = 1'b1;
                  eq_in        = '0;
                  state_in     = S_IDLE;
               end else begin
                  j_in = CW'(j_ff + 1'b1);
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/gf2_equation_solver.sv =====
// GF(2) equation solver for an LT decoder.
// Input words (req_*): mode 0 loads one equation (coefficient mask and
// payload) into the next free row; mode 1 solves the stored system.
// Result words (rsp_*) leave through one output register; rsp_stall holds
// the word in place and the block waits for the slot to free up.
// Load, drop and too-few-rows answers appear one cycle after acceptance,
// one input word per cycle while rsp_stall is low.
// A decode over n rows uses one shared row-XOR unit and one store read port,
// one row per cycle; a column that needs a row swap takes an extra swap step,
// then n result words leave at one per cycle while the output slot is free.
// req_stall stays high for the whole decode.
// csr_* writes the block count (6 bits); csr_ready is high while idle.
// Reset (synchronous) empties the store, sets the block count to 32 and
// drops any pending result word. The store is also emptied after a decode.
`include "gf2_equation_solver_defines.svh"

module gf2_equation_solver #(
   parameter int MAX_BLOCKS   = 32,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gf2s_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gf2s_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gf2s_pkg::CFG_BITS-1:0]     csr_data
);
   import gf2s_pkg::*;

   localparam int ROW_CAP = (MAX_BLOCKS < 32) ? MAX_BLOCKS : 32;
   localparam int IW      = $clog2(ROW_CAP);
   localparam int CW      = IW + 1;
   localparam logic [CFG_BITS-1:0] CAP_CFG = CFG_BITS'(ROW_CAP);

   logic [CFG_BITS-1:0]   csr_ff, csr_in;
   logic [CFG_BITS-1:0]   n_raw;
   logic [CW-1:0]         n_use;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  out_free;
   logic                  req_accept;
   logic                  idle;
   logic                  res_load;
   rsp_type               res;
   wr_ctl_type            wr_ctl;
   logic [IW-1:0]         wr_idx;
   logic [ROW_CAP-1:0]    wr_coeff;
   logic [PAYLOAD_BITS-1:0] wr_pay;
   logic [IW-1:0]         rd_idx;
   logic [ROW_CAP-1:0]    rd_coeff;
   logic [PAYLOAD_BITS-1:0] rd_pay;

   // Handshakes
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !(idle && out_free);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = idle;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Block count register
   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         csr_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= SOURCE_BLOCKS_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Clamp block count to 1..row capacity
   always_comb begin
      if (csr_ff == '0) begin
         n_raw = CFG_BITS'(1);
      end else if (csr_ff > CAP_CFG) begin
         n_raw = CAP_CFG;
      end else begin
         n_raw = csr_ff;
      end
      n_use = CW'(n_raw);
   end

   // Output register: load a new word or drop the taken one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   gf2s_store #(
      .ROWS (ROW_CAP),
      .PB   (PAYLOAD_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_ctl   (wr_ctl),
      .wr_idx   (wr_idx),
      .wr_coeff (wr_coeff),
      .wr_pay   (wr_pay),
      .rd_idx   (rd_idx),
      .rd_coeff (rd_coeff),
      .rd_pay   (rd_pay)
   );

   gf2s_seq #(
      .ROWS (ROW_CAP),
      .PB   (PAYLOAD_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .n          (n_use),
      .req_accept (req_accept),
      .req_data   (req_data),
      .out_free   (out_free),
      .rd_coeff   (rd_coeff),
      .rd_pay     (rd_pay),
      .idle       (idle),
      .res_load   (res_load),
      .res        (res),
      .wr_ctl     (wr_ctl),
      .wr_idx     (wr_idx),
      .wr_coeff   (wr_coeff),
      .wr_pay     (wr_pay),
      .rd_idx     (rd_idx)
   );

   // Checks
   `GF2S_ASSERT_IMPL(a_load_when_free, clock, reset, res_load, out_free,
      "result word overwrote a held word")
   `GF2S_ASSERT_NEXT(a_load_answers, clock, reset,
      req_accept && req_data.mode == MODE_LOAD, rsp_valid_ff && rsp_data_ff.last,
      "load word gave no answer")
   `GF2S_ASSERT_IMPL(a_last_idle, clock, reset,
      rsp_valid_ff && rsp_data_ff.status == ST_SOLVED && rsp_data_ff.last, idle,
      "sequencer busy after last solved word")
   `GF2S_ASSERT_IMPL(a_emit_busy, clock, reset,
      rsp_valid_ff && rsp_data_ff.status == ST_SOLVED && !rsp_data_ff.last, !idle,
      "sequencer idle with solved words left")

endmodule
